@@ design/gcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

    // Operand and digit geometry.
    localparam int OPERAND_WIDTH = 32;
    localparam int MAG_WIDTH     = OPERAND_WIDTH - 1;
    localparam int DIGIT_WIDTH   = 4;
    localparam int NUM_DIGITS    = (MAG_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int REG_WIDTH     = NUM_DIGITS * DIGIT_WIDTH;
    localparam int CNT_WIDTH     = $clog2(NUM_DIGITS);
    localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);

    typedef logic [REG_WIDTH-1:0]   mag_t;
    typedef logic [DIGIT_WIDTH-1:0] digit_t;

    // Operations that the controller asks of the datapath.
    typedef enum logic [3:0] {
        DP_HOLD,
        DP_LOAD,
        DP_LOAD_ZERO,
        DP_HALVE_BOTH,
        DP_HALVE_A,
        DP_HALVE_B,
        DP_SUB_STEP,
        DP_TAKE_AB,
        DP_TAKE_BA,
        DP_DOUBLE_A
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   first_digit;
    } dp_ctrl_t;

    typedef struct packed {
        logic a_lsb;
        logic b_lsb;
        logic a_below_b;
        logic equal;
    } dp_status_t;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_SUB    = 6'b000100,
        S_DECIDE = 6'b001000,
        S_SCALE  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

@@ design/gcd_digit_sub.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcd_digit_sub
    import gcd_pkg::*;
(
    input  wire digit_t minuend,
    input  wire digit_t subtrahend,
    input  wire logic   borrow_in,
    output digit_t      difference,
    output logic        borrow_out
);

    logic [DIGIT_WIDTH:0] wide_diff;

    // One digit of a ripple subtraction; the extra top bit is the borrow.
    always_comb
    begin
        wide_diff = {1'b0, minuend} - {1'b0, subtrahend}
                    - {{DIGIT_WIDTH{1'b0}}, borrow_in};
        difference = wide_diff[DIGIT_WIDTH-1:0];
        borrow_out = wide_diff[DIGIT_WIDTH];
    end

endmodule

`default_nettype wire

@@ design/gcd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcd_datapath
    import gcd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic [OPERAND_WIDTH-1:0] first_value,
    input  wire logic [OPERAND_WIDTH-1:0] second_value,
    input  wire dp_ctrl_t                 ctrl,
    output dp_status_t                    status,
    output mag_t                          a_value
);

    mag_t   a_reg, a_next;
    mag_t   b_reg, b_next;
    mag_t   dab_reg, dab_next;
    mag_t   dba_reg, dba_next;
    logic   bab_reg, bab_next;
    logic   bba_reg, bba_next;
    logic   eq_reg, eq_next;
    digit_t diff_ab, diff_ba;
    logic   bout_ab, bout_ba;
    logic   bin_ab, bin_ba;

    // The first digit of a pass starts with no borrow.
    assign bin_ab = ctrl.first_digit ? 1'b0 : bab_reg;
    assign bin_ba = ctrl.first_digit ? 1'b0 : bba_reg;

    gcd_digit_sub u_sub_ab (
        .minuend    (a_reg[DIGIT_WIDTH-1:0]),
        .subtrahend (b_reg[DIGIT_WIDTH-1:0]),
        .borrow_in  (bin_ab),
        .difference (diff_ab),
        .borrow_out (bout_ab)
    );

    gcd_digit_sub u_sub_ba (
        .minuend    (b_reg[DIGIT_WIDTH-1:0]),
        .subtrahend (a_reg[DIGIT_WIDTH-1:0]),
        .borrow_in  (bin_ba),
        .difference (diff_ba),
        .borrow_out (bout_ba)
    );

    // Next values of the operand and difference shift registers.
    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        dab_next = dab_reg;
        dba_next = dba_reg;
        bab_next = bab_reg;
        bba_next = bba_reg;
        eq_next  = eq_reg;
        unique case (ctrl.op)
            DP_LOAD:
            begin
                a_next = REG_WIDTH'(first_value[MAG_WIDTH-1:0]);
                b_next = REG_WIDTH'(second_value[MAG_WIDTH-1:0]);
            end
            DP_LOAD_ZERO:
            begin
                a_next = '0;
            end
            DP_HALVE_BOTH:
            begin
                a_next = {1'b0, a_reg[REG_WIDTH-1:1]};
                b_next = {1'b0, b_reg[REG_WIDTH-1:1]};
            end
            DP_HALVE_A:
            begin
                a_next = {1'b0, a_reg[REG_WIDTH-1:1]};
            end
            DP_HALVE_B:
            begin
                b_next = {1'b0, b_reg[REG_WIDTH-1:1]};
            end
            DP_SUB_STEP:
            begin
                // Operands rotate one digit; differences fill from the top.
                a_next   = {a_reg[DIGIT_WIDTH-1:0], a_reg[REG_WIDTH-1:DIGIT_WIDTH]};
                b_next   = {b_reg[DIGIT_WIDTH-1:0], b_reg[REG_WIDTH-1:DIGIT_WIDTH]};
                dab_next = {diff_ab, dab_reg[REG_WIDTH-1:DIGIT_WIDTH]};
                dba_next = {diff_ba, dba_reg[REG_WIDTH-1:DIGIT_WIDTH]};
                bab_next = bout_ab;
                bba_next = bout_ba;
                eq_next  = (ctrl.first_digit | eq_reg) & (diff_ab == '0);
            end
            DP_TAKE_AB:
            begin
                // Both operands were odd, so the difference is even.
                a_next = {1'b0, dab_reg[REG_WIDTH-1:1]};
            end
            DP_TAKE_BA:
            begin
                b_next = {1'b0, dba_reg[REG_WIDTH-1:1]};
            end
            DP_DOUBLE_A:
            begin
                a_next = {a_reg[REG_WIDTH-2:0], 1'b0};
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        dab_reg <= dab_next;
        dba_reg <= dba_next;
        bab_reg <= bab_next;
        bba_reg <= bba_next;
        eq_reg  <= eq_next;
    end

    assign status.a_lsb     = a_reg[0];
    assign status.b_lsb     = b_reg[0];
    assign status.a_below_b = bab_reg;
    assign status.equal     = eq_reg;
    assign a_value          = a_reg;

endmodule

`default_nettype wire

@@ design/greatest_common_divisor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     start, busy          first_value[31:0], second_value[31:0] (signed)
// result    done (strobe)        divisor_result[30:0]
//
// Binary GCD over digit-serial shift registers, four bits per cycle.
// Each odd/odd subtraction pass runs the digits through S_SUB and then S_DECIDE,
// each halving is one S_REDUCE step, each shared factor of two one S_SCALE doubling.
// A non-positive operand gives 0 in the next cycle.
// Reset returns the controller to idle; an item may start in the done cycle.
// The result strobe lasts one cycle and cannot be held off.

module greatest_common_divisor
    import gcd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OPERAND_WIDTH-1:0] first_value,
    input  wire logic [OPERAND_WIDTH-1:0] second_value,
    output logic                          done,
    output logic [MAG_WIDTH-1:0]          divisor_result
);

    state_t                 state_reg, state_next;
    logic [SHIFT_WIDTH-1:0] k_reg, k_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    dp_ctrl_t               ctrl;
    dp_status_t             status;
    mag_t                   a_value;
    logic                   accept;
    logic                   both_positive;

    gcd_datapath u_datapath (
        .clk          (clk),
        .first_value  (first_value),
        .second_value (second_value),
        .ctrl         (ctrl),
        .status       (status),
        .a_value      (a_value)
    );

    // An operand counts only when its sign is clear and it is nonzero.
    assign both_positive = ~first_value[OPERAND_WIDTH-1] & (|first_value[MAG_WIDTH-1:0])
                         & ~second_value[OPERAND_WIDTH-1] & (|second_value[MAG_WIDTH-1:0]);

    assign busy   = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign accept = start & ~busy;

    // Controller sequencing of reduce, subtract and rescale steps.
    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        cnt_next         = cnt_reg;
        ctrl.op          = DP_HOLD;
        ctrl.first_digit = 1'b0;
        unique case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    k_next = '0;
                    if (both_positive)
                    begin
                        ctrl.op    = DP_LOAD;
                        state_next = S_REDUCE;
                    end
                    else
                    begin
                        ctrl.op    = DP_LOAD_ZERO;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REDUCE:
            begin
                priority if (!status.a_lsb && !status.b_lsb)
                begin
                    ctrl.op = DP_HALVE_BOTH;
                    k_next  = k_reg + 1'b1;
                end
                else if (!status.a_lsb)
                begin
                    ctrl.op = DP_HALVE_A;
                end
                else if (!status.b_lsb)
                begin
                    ctrl.op = DP_HALVE_B;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                ctrl.op          = DP_SUB_STEP;
                ctrl.first_digit = (cnt_reg == '0);
                cnt_next         = cnt_reg + 1'b1;
                if (cnt_reg == CNT_WIDTH'(NUM_DIGITS - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (!status.a_below_b && status.equal)
                begin
                    state_next = (k_reg == '0) ? S_DONE : S_SCALE;
                end
                else if (!status.a_below_b)
                begin
                    ctrl.op    = DP_TAKE_AB;
                    state_next = S_REDUCE;
                end
                else
                begin
                    ctrl.op    = DP_TAKE_BA;
                    state_next = S_REDUCE;
                end
            end
            S_SCALE:
            begin
                ctrl.op = DP_DOUBLE_A;
                k_next  = k_reg - 1'b1;
                if (k_reg == SHIFT_WIDTH'(1))
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign done           = (state_reg == S_DONE);
    assign divisor_result = a_value[MAG_WIDTH-1:0];

endmodule

`default_nettype wire

@@ design/gcd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcd_checker
    import gcd_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic [OPERAND_WIDTH-1:0] first_value,
    input wire logic [OPERAND_WIDTH-1:0] second_value,
    input wire logic                     done,
    input wire logic [MAG_WIDTH-1:0]     divisor_result
);

    logic first_bad;
    logic second_bad;

    assign first_bad  = first_value[OPERAND_WIDTH-1] || (first_value == '0);
    assign second_bad = second_value[OPERAND_WIDTH-1] || (second_value == '0);

    // A non-positive operand gives a zero result in the next cycle.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (first_bad || second_bad)) |=> (done && divisor_result == '0))
        else $error("non-positive operand did not give an immediate zero result");

    // Two positive operands always start a computation.
    a_positive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !first_bad && !second_bad) |=> (busy && !done))
        else $error("positive operands did not start a computation");

    // The result strobe only appears while a new item may be taken.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Work begins only when an item has been accepted.
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    // A finished computation returns a nonzero divisor.
    a_busy_ends_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy) && done) |-> (divisor_result != '0))
        else $error("computation finished with a zero divisor");

endmodule

bind greatest_common_divisor gcd_checker u_gcd_checker (.*);

`default_nettype wire

@@ test/greatest_common_divisor_tb.sv @@
`timescale 1ns / 1ps

module greatest_common_divisor_tb;

    import gcd_pkg::*;

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [MAG_WIDTH-1:0]     gcd_t;

    // One row of directed stimulus; the result is typed in only where pinned is set.
    typedef struct packed {
        operand_t first;
        operand_t second;
        bit       pinned;
        gcd_t     want;
    } gcd_row_t;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 700;

    localparam gcd_row_t DIRECTED_ROWS [0:23] = '{
        '{32'd12,          32'd18,          1'b1, 31'd6},
        '{32'd0,           32'd0,           1'b1, 31'd0},
        '{32'd0,           32'd5,           1'b1, 31'd0},
        '{32'd5,           32'd0,           1'b1, 31'd0},
        '{32'hFFFF_FFFF,   32'd7,           1'b1, 31'd0},
        '{32'd7,           32'hFFFF_FFFF,   1'b1, 31'd0},
        '{32'h8000_0000,   32'h8000_0000,   1'b1, 31'd0},
        '{32'hFFFF_FFFF,   32'hFFFF_FFFF,   1'b1, 31'd0},
        '{32'h8000_0000,   32'h7FFF_FFFF,   1'b1, 31'd0},
        '{32'h7FFF_FFFF,   32'h8000_0000,   1'b1, 31'd0},
        '{32'd1,           32'd0,           1'b1, 31'd0},
        '{32'h7FFF_FFFF,   32'h7FFF_FFFF,   1'b1, 31'h7FFF_FFFF},
        '{32'd1,           32'd1,           1'b1, 31'd1},
        '{32'd1,           32'h7FFF_FFFF,   1'b1, 31'd1},
        '{32'h7FFF_FFFF,   32'd1,           1'b1, 31'd1},
        '{32'h4000_0000,   32'h4000_0000,   1'b1, 31'h4000_0000},
        '{32'd37,          32'd37,          1'b1, 31'd37},
        '{32'h4000_0000,   32'h2000_0000,   1'b0, 31'd0},
        '{32'h7FFF_FFFF,   32'h7FFF_FFFE,   1'b0, 31'd0},
        '{32'd1071,        32'd462,         1'b0, 31'd0},
        '{32'd2147483646,  32'd1073741823,  1'b0, 31'd0},
        '{32'h6000_0000,   32'h3000_0000,   1'b0, 31'd0},
        '{32'd1836311903,  32'd1134903170,  1'b0, 31'd0},
        '{32'h5555_5555,   32'h2AAA_AAAA,   1'b0, 31'd0}
    };

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    operand_t first_value;
    operand_t second_value;
    logic     done;
    gcd_t     divisor_result;

    // Expected divisors in the order their items were accepted.
    gcd_t     pending_gcds [$];
    int       mismatch_count;
    bit       gaps_on;
    bit       pinned;
    gcd_t     pinned_gcd;

    greatest_common_divisor DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_value    (first_value),
        .second_value   (second_value),
        .done           (done),
        .divisor_result (divisor_result)
    );

    always #2 clk = ~clk;

    // Euclid on the magnitudes; zero whenever either operand is not strictly positive.
    function automatic gcd_t gcd_of(input operand_t a, input operand_t b);
        operand_t x;
        operand_t y;
        operand_t r;
        if (a[OPERAND_WIDTH-1] || a == '0 || b[OPERAND_WIDTH-1] || b == '0)
            return '0;
        x = a;
        y = b;
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x[MAG_WIDTH-1:0];
    endfunction

    // Random value confined to the low w bits (w at most 31).
    function automatic operand_t span_rand(input int unsigned w);
        return operand_t'($urandom) & ((operand_t'(1) << w) - 1);
    endfunction

    // Results are checked before the item accepted at the same edge is recorded.
    always @(posedge clk)
    begin
        gcd_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_gcds.size() == 0)
            begin
                $error("divisor_result: no item outstanding, actual %0d", divisor_result);
                mismatch_count++;
            end
            else
            begin
                want = pending_gcds.pop_front();
                if (divisor_result !== want)
                begin
                    $error("divisor_result: expected %0d, actual %0d", want, divisor_result);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && start === 1'b1 && busy === 1'b0)
            pending_gcds.push_back(pinned ? pinned_gcd : gcd_of(first_value, second_value));
    end

    // After optional random idle gaps, present one item at the falling edge and hold it until the block takes it.
    task automatic issue(input operand_t a, input operand_t b, input bit fixed, input gcd_t want);
        while (gaps_on && $urandom_range(0, 99) < 21)
        begin
            start = 1'b0;
            first_value = $urandom;
            second_value = $urandom;
            @(negedge clk);
        end
        start = 1'b1;
        first_value = a;
        second_value = b;
        pinned = fixed;
        pinned_gcd = want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Mostly operand pairs with a common factor, plus full-range, equal and non-positive ones.
    task automatic random_pair(output operand_t a, output operand_t b);
        int unsigned kind;
        int unsigned gw;
        int unsigned shift;
        operand_t    g;
        operand_t    t;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (kind < 5)
        begin
            a = $urandom_range(0, 1) ? '0 : (operand_t'($urandom) | 32'h8000_0000);
            b = $urandom_range(1, 32'h7FFF_FFFF);
            if ($urandom_range(0, 1))
            begin
                t = a;
                a = b;
                b = t;
            end
        end
        else if (kind == 5)
        begin
            a = span_rand($urandom_range(1, 31));
            b = a;
        end
        else
        begin
            gw = $urandom_range(1, 12);
            shift = $urandom_range(0, 6);
            g = span_rand(gw) | 1;
            a = (g * span_rand($urandom_range(1, 31 - gw - shift))) << shift;
            b = (g * span_rand($urandom_range(1, 31 - gw - shift))) << shift;
        end
    endtask

    initial
    begin
        #12_000_000;
        $display("[greatest_common_divisor] ERROR");
        $finish;
    end

    initial
    begin
        operand_t a;
        operand_t b;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        first_value = '0;
        second_value = '0;
        mismatch_count = 0;
        gaps_on = 1'b1;
        pinned = 1'b0;
        pinned_gcd = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: extremes, non-positive operands, equal operands.
        foreach (DIRECTED_ROWS[i])
            issue(DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].second,
                  DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);

        // Random items, with a stretch in the middle where the sender never pauses.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 400 && n < 700);
            random_pair(a, b);
            issue(a, b, 1'b0, '0);
        end
        start = 1'b0;
        pinned = 1'b0;

        // Drain outstanding results, then watch for stray strobes.
        while (pending_gcds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[greatest_common_divisor] OK");
        else
            $display("[greatest_common_divisor] ERROR");
        $finish;
    end

endmodule
